// ----- sv/kway_merge_sum_saturate_assert.svh -----
// ----------------------------------------------------------------------------
// kway_merge_sum_saturate assertion macros
// Concurrent assertion wrappers shared by the merge RTL; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef KWAY_MERGE_SUM_SATURATE_ASSERT_SVH
`define KWAY_MERGE_SUM_SATURATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define KMS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KMS_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define KMS_ASSERT(lbl, clk, rst, prop, msg)
`define KMS_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- sv/kms_pkg.sv -----
// ----------------------------------------------------------------------------
// kms_pkg
// Port widths, parameter defaults and cell control and status types for the K-way merge.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int PORT_KEY_W   = 64;
  localparam int PORT_COUNT_W = 32;
  localparam int PORT_MASK_W  = 8;
  localparam int PORT_ID_W    = 3;
  localparam int CFG_W        = 4;

  localparam int DEF_MAX_STREAMS = 8;
  localparam int DEF_KEY_BITS    = 64;
  localparam int DEF_COUNT_BITS  = 32;

  localparam logic [CFG_W-1:0] RESET_STREAM_COUNT = CFG_W'(2);

  typedef struct packed {
    logic active;
    logic load;
    logic finish;
    logic update;
    logic consume;
    logic restart;
  } kms_cell_ctrl_t;

  typedef struct packed {
    logic ready;
    logic holds;
    logic present;
    logic finished;
  } kms_cell_status_t;

endpackage

// ----- sv/kms_cell.sv -----
// ----------------------------------------------------------------------------
// kms_cell
// One stream slot: holds the stream head and folds it into the running
// minimum key, saturating count sum and consumed mask passed along the row.
// ----------------------------------------------------------------------------
module kms_cell
  import kms_pkg::*;
#(
  parameter int MAX_STREAMS = DEF_MAX_STREAMS,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kms_cell_ctrl_t         ctrl,
  input  logic [KEY_BITS-1:0]    in_key,
  input  logic [COUNT_BITS-1:0]  in_count,
  input  logic                   left_any,
  input  logic [KEY_BITS-1:0]    left_key,
  input  logic [COUNT_BITS-1:0]  left_sum,
  input  logic [MAX_STREAMS-1:0] left_mask,
  output logic                   right_any,
  output logic [KEY_BITS-1:0]    right_key,
  output logic [COUNT_BITS-1:0]  right_sum,
  output logic [MAX_STREAMS-1:0] right_mask,
  output kms_cell_status_t       status
);

  localparam logic [MAX_STREAMS-1:0] OWN_BIT = MAX_STREAMS'(1) << IDX;

  logic [KEY_BITS-1:0]   head_key;
  logic [COUNT_BITS-1:0] head_count;
  logic                  present;
  logic                  finished;

  logic                  load_ok;
  logic [KEY_BITS-1:0]   key_v;
  logic [COUNT_BITS-1:0] cnt_v;
  logic                  pres_v;
  logic                  fin_v;
  logic [COUNT_BITS:0]   sum_wide;

  always_comb begin
    load_ok  = ctrl.load && !finished;
    key_v    = load_ok ? in_key : head_key;
    cnt_v    = load_ok ? in_count : head_count;
    pres_v   = present || load_ok;
    fin_v    = finished || ctrl.finish;
    sum_wide = {1'b0, left_sum} + {1'b0, cnt_v};

    right_any  = left_any;
    right_key  = left_key;
    right_sum  = left_sum;
    right_mask = left_mask;
    if (ctrl.active && pres_v) begin
      if (!left_any || key_v < left_key) begin
        right_any  = 1'b1;
        right_key  = key_v;
        right_sum  = cnt_v;
        right_mask = OWN_BIT;
      end else if (key_v == left_key) begin
        right_sum  = sum_wide[COUNT_BITS] ? '1 : sum_wide[COUNT_BITS-1:0];
        right_mask = left_mask | OWN_BIT;
      end
    end

    status.ready    = !ctrl.active || pres_v || fin_v;
    status.holds    = ctrl.active && pres_v;
    status.present  = present;
    status.finished = finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= 1'b0;
      finished <= 1'b0;
    end else if (ctrl.update) begin
      present  <= pres_v && !ctrl.consume;
      finished <= fin_v && !ctrl.restart;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update && load_ok) begin
      head_key   <= in_key;
      head_count <= in_count;
    end
  end

endmodule

// ----- sv/kway_merge_sum_saturate.sv -----
// ----------------------------------------------------------------------------
// kway_merge_sum_saturate
// Merges up to MAX_STREAMS ascending key streams into one ascending stream,
// summing the counts of equal keys with saturation.
//
//   channel  handshake            payload
//   -------  -------------------  ----------------------------------------------
//   in       in_valid / in_ready  stream_id, key, count, exhausted
//   out      out_valid/out_ready  merged_key, merged_count, consumed_mask,
//                                 block_end
//   cfg      cfg_we               cfg_wdata (stream_count)
//
// One input beat is taken every cycle while in_ready is high; its result, if
// any, goes to the output register or, while the output stalls, to the skid
// entry. The minimum search runs along the row of stream cells in the same
// cycle as the head update. Reset clears all head and exhaustion marks, sets
// stream_count to 2 and empties the output. The output register plus one skid
// entry absorb stalls; in_ready drops only while the skid entry is occupied.
// ----------------------------------------------------------------------------
`include "kway_merge_sum_saturate_assert.svh"

module kway_merge_sum_saturate
  import kms_pkg::*;
#(
  parameter int MAX_STREAMS = DEF_MAX_STREAMS,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PORT_ID_W-1:0]    stream_id,
  input  logic [PORT_KEY_W-1:0]   key,
  input  logic [PORT_COUNT_W-1:0] count,
  input  logic                    exhausted,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PORT_KEY_W-1:0]   merged_key,
  output logic [PORT_COUNT_W-1:0] merged_count,
  output logic [PORT_MASK_W-1:0]  consumed_mask,
  output logic                    block_end
);

  localparam int NW = $clog2(MAX_STREAMS + 1);

  logic [CFG_W-1:0] stream_count;
  logic [NW-1:0]    n_eff;

  logic [KEY_BITS+PORT_KEY_W-1:0]     key_ext;
  logic [COUNT_BITS+PORT_COUNT_W-1:0] count_ext;
  logic [KEY_BITS-1:0]                in_key;
  logic [COUNT_BITS-1:0]              in_count;

  logic                   chain_any  [MAX_STREAMS+1];
  logic [KEY_BITS-1:0]    chain_key  [MAX_STREAMS+1];
  logic [COUNT_BITS-1:0]  chain_sum  [MAX_STREAMS+1];
  logic [MAX_STREAMS-1:0] chain_mask [MAX_STREAMS+1];

  kms_cell_ctrl_t   ctrl   [MAX_STREAMS];
  kms_cell_status_t status [MAX_STREAMS];

  logic [MAX_STREAMS-1:0] ready_vec;
  logic [MAX_STREAMS-1:0] holds_vec;
  logic [MAX_STREAMS-1:0] present_vec;
  logic [MAX_STREAMS-1:0] finished_vec;

  logic in_fire;
  logic out_fire;
  logic res_valid;
  logic res_end;
  logic push;

  logic [PORT_KEY_W-1:0]   res_key;
  logic [PORT_COUNT_W-1:0] res_count;
  logic [PORT_MASK_W-1:0]  res_mask;

  logic [KEY_BITS+PORT_KEY_W-1:0]       res_key_ext;
  logic [COUNT_BITS+PORT_COUNT_W-1:0]   res_count_ext;
  logic [MAX_STREAMS+PORT_MASK_W-1:0]   res_mask_ext;

  logic                    skid_valid;
  logic [PORT_KEY_W-1:0]   skid_key;
  logic [PORT_COUNT_W-1:0] skid_count;
  logic [PORT_MASK_W-1:0]  skid_mask;
  logic                    skid_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_count <= RESET_STREAM_COUNT;
    end else if (cfg_we) begin
      stream_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (stream_count == '0) begin
      n_eff = NW'(1);
    end else if (int'(stream_count) > MAX_STREAMS) begin
      n_eff = NW'(MAX_STREAMS);
    end else begin
      n_eff = NW'(stream_count);
    end
  end

  assign key_ext   = {{KEY_BITS{1'b0}}, key};
  assign count_ext = {{COUNT_BITS{1'b0}}, count};
  assign in_key    = key_ext[KEY_BITS-1:0];
  assign in_count  = count_ext[COUNT_BITS-1:0];

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign chain_any[0]  = 1'b0;
  assign chain_key[0]  = '0;
  assign chain_sum[0]  = '0;
  assign chain_mask[0] = '0;

  for (genvar i = 0; i < MAX_STREAMS; i++) begin : g_cell
    logic hit;

    assign hit = (i < int'(n_eff)) && (int'(stream_id) == i);

    always_comb begin
      ctrl[i].active  = i < int'(n_eff);
      ctrl[i].load    = hit && !exhausted;
      ctrl[i].finish  = hit && exhausted;
      ctrl[i].update  = in_fire;
      ctrl[i].consume = res_valid && !res_end && chain_mask[MAX_STREAMS][i];
      ctrl[i].restart = res_valid && res_end;
    end

    kms_cell #(
      .MAX_STREAMS (MAX_STREAMS),
      .KEY_BITS    (KEY_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .IDX         (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl[i]),
      .in_key     (in_key),
      .in_count   (in_count),
      .left_any   (chain_any[i]),
      .left_key   (chain_key[i]),
      .left_sum   (chain_sum[i]),
      .left_mask  (chain_mask[i]),
      .right_any  (chain_any[i+1]),
      .right_key  (chain_key[i+1]),
      .right_sum  (chain_sum[i+1]),
      .right_mask (chain_mask[i+1]),
      .status     (status[i])
    );

    assign ready_vec[i]    = status[i].ready;
    assign holds_vec[i]    = status[i].holds;
    assign present_vec[i]  = status[i].present;
    assign finished_vec[i] = status[i].finished;
  end

  assign res_valid = &ready_vec;
  assign res_end   = !(|holds_vec);
  assign push      = in_fire && res_valid;

  assign res_key_ext   = {{PORT_KEY_W{1'b0}}, chain_key[MAX_STREAMS]};
  assign res_count_ext = {{PORT_COUNT_W{1'b0}}, chain_sum[MAX_STREAMS]};
  assign res_mask_ext  = {{PORT_MASK_W{1'b0}}, chain_mask[MAX_STREAMS]};

  assign res_key   = res_end ? '0 : res_key_ext[PORT_KEY_W-1:0];
  assign res_count = res_end ? '0 : res_count_ext[PORT_COUNT_W-1:0];
  assign res_mask  = res_end ? '0 : res_mask_ext[PORT_MASK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        merged_key    <= skid_key;
        merged_count  <= skid_count;
        consumed_mask <= skid_mask;
        block_end     <= skid_end;
      end else begin
        merged_key    <= res_key;
        merged_count  <= res_count;
        consumed_mask <= res_mask;
        block_end     <= res_end;
      end
    end
    if (push && (skid_valid || (out_valid && !out_fire))) begin
      skid_key   <= res_key;
      skid_count <= res_count;
      skid_mask  <= res_mask;
      skid_end   <= res_end;
    end
  end

  `KMS_NEVER(a_skid_behind_out, clk, rst, skid_valid && !out_valid,
             "Skid entry occupied while the output register is empty.")
  `KMS_ASSERT(a_end_clears_marks, clk, rst, push && res_end |=> finished_vec == '0,
              "Exhaustion marks survived a block end.")
  `KMS_ASSERT(a_consumed_cleared, clk, rst,
              push && !res_end |=> (present_vec & $past(chain_mask[MAX_STREAMS])) == '0,
              "A consumed head is still marked present.")
  `KMS_NEVER(a_merge_has_source, clk, rst, push && !res_end && chain_mask[MAX_STREAMS] == '0,
             "Merged result without any consumed stream.")

endmodule

// ----- sim/kway_merge_sum_saturate_tb.sv -----
// ----------------------------------------------------------------------------
// kway_merge_sum_saturate_tb
// Self-checking testbench for the K-way merge with saturating duplicate sums.
// A behavioral copy of the merge state predicts every output beat as each
// input beat is accepted. A directed part covers count saturation, key
// extremes, head overwrite, ignored beats, exhaustion with a held head and
// stream-count edge values. Many random merge blocks follow under several
// stream-count settings, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module kway_merge_sum_saturate_tb;
  import kms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_BEATS = 1500;
  localparam logic [PORT_KEY_W-1:0] KEY_ONES = '1;

  typedef struct packed {
    logic [PORT_ID_W-1:0]    stream_id;
    logic [PORT_KEY_W-1:0]   key;
    logic [PORT_COUNT_W-1:0] count;
    logic                    exhausted;
  } in_beat_t;

  typedef struct packed {
    logic [PORT_KEY_W-1:0]   merged_key;
    logic [PORT_COUNT_W-1:0] merged_count;
    logic [PORT_MASK_W-1:0]  consumed_mask;
    logic                    block_end;
  } merge_beat_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [PORT_ID_W-1:0]    stream_id = '0;
  logic [PORT_KEY_W-1:0]   key = '0;
  logic [PORT_COUNT_W-1:0] count = '0;
  logic                    exhausted = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [PORT_KEY_W-1:0]   merged_key;
  logic [PORT_COUNT_W-1:0] merged_count;
  logic [PORT_MASK_W-1:0]  consumed_mask;
  logic                    block_end;

  logic [PORT_KEY_W-1:0]      lane_key [DEF_MAX_STREAMS];
  logic [PORT_COUNT_W-1:0]    lane_count [DEF_MAX_STREAMS];
  logic [DEF_MAX_STREAMS-1:0] lane_held;
  logic [DEF_MAX_STREAMS-1:0] lane_done;
  logic [CFG_W-1:0]           stream_count_cfg;
  logic                       block_closed;

  merge_beat_t pending_merges[$];
  int unsigned mismatch_count;
  int unsigned accepted_beats;
  int unsigned merged_beats;
  int unsigned block_ends;
  int unsigned saturated_sums;
  int unsigned settings_used;
  int unsigned cycle_count;

  kway_merge_sum_saturate u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .stream_id    (stream_id),
    .key          (key),
    .count        (count),
    .exhausted    (exhausted),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .merged_key   (merged_key),
    .merged_count (merged_count),
    .consumed_mask(consumed_mask),
    .block_end    (block_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $error("Run timed out after %0d cycles.", cycle_count);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned lanes_in_use();
    if (stream_count_cfg == '0) return 1;
    if (stream_count_cfg > CFG_W'(DEF_MAX_STREAMS)) return DEF_MAX_STREAMS;
    return stream_count_cfg;
  endfunction

  function automatic void merge_predict(in_beat_t b);
    int unsigned n;
    merge_beat_t r;
    logic found;
    logic [PORT_COUNT_W:0] total;
    n = lanes_in_use();
    if (b.stream_id < n) begin
      if (b.exhausted) begin
        lane_done[b.stream_id] = 1'b1;
      end else if (!lane_done[b.stream_id]) begin
        lane_key[b.stream_id] = b.key;
        lane_count[b.stream_id] = b.count;
        lane_held[b.stream_id] = 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!lane_held[i] && !lane_done[i]) return;
    end
    r = '0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (lane_held[i]) begin
        if (!found || lane_key[i] < r.merged_key) begin
          found = 1'b1;
          r.merged_key = lane_key[i];
          r.merged_count = lane_count[i];
          r.consumed_mask = PORT_MASK_W'(1) << i;
        end else if (lane_key[i] == r.merged_key) begin
          total = {1'b0, r.merged_count} + {1'b0, lane_count[i]};
          if (total[PORT_COUNT_W]) saturated_sums++;
          r.merged_count = total[PORT_COUNT_W] ? '1 : total[PORT_COUNT_W-1:0];
          r.consumed_mask |= PORT_MASK_W'(1) << i;
        end
      end
    end
    if (!found) begin
      lane_done = '0;
      r.block_end = 1'b1;
      block_closed = 1'b1;
      block_ends++;
    end else begin
      lane_held &= ~DEF_MAX_STREAMS'(r.consumed_mask);
      merged_beats++;
    end
    pending_merges.push_back(r);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_beat_t make_beat(int unsigned id, logic [PORT_KEY_W-1:0] k,
                                         logic [PORT_COUNT_W-1:0] c, logic e);
    in_beat_t b;
    b.stream_id = PORT_ID_W'(id);
    b.key = k;
    b.count = c;
    b.exhausted = e;
    return b;
  endfunction

  function automatic in_beat_t noise_beat();
    return make_beat($urandom_range(0, DEF_MAX_STREAMS - 1), {$urandom, $urandom},
                     $urandom, $urandom_range(0, 3) == 0);
  endfunction

  function automatic logic [PORT_COUNT_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
    if (roll == 1) return $urandom;
    return $urandom_range(0, 255);
  endfunction

  task automatic send_beat(in_beat_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_id <= b.stream_id;
    key <= b.key;
    count <= b.count;
    exhausted <= b.exhausted;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (b.stream_id < lanes_in_use() && (b.exhausted || !lane_done[b.stream_id]))
      accepted_beats++;
    merge_predict(b);
  endtask

  task automatic wait_merges_done();
    in_valid <= 1'b0;
    while (pending_merges.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_stream_count(logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    stream_count_cfg = value;
    settings_used++;
    cfg_we <= 1'b0;
  endtask

  initial begin
    merge_beat_t exp;
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_merges.size() == 0) begin
          $error("Output beat with no prediction: key %h count %h mask %h end %b.",
                 merged_key, merged_count, consumed_mask, block_end);
          mismatch_count++;
        end else begin
          exp = pending_merges.pop_front();
          if (merged_key !== exp.merged_key) begin
            $error("merged_key: expected %h, got %h", exp.merged_key, merged_key);
            mismatch_count++;
          end
          if (merged_count !== exp.merged_count) begin
            $error("merged_count: expected %h, got %h", exp.merged_count, merged_count);
            mismatch_count++;
          end
          if (consumed_mask !== exp.consumed_mask) begin
            $error("consumed_mask: expected %h, got %h", exp.consumed_mask, consumed_mask);
            mismatch_count++;
          end
          if (block_end !== exp.block_end) begin
            $error("block_end: expected %b, got %b", exp.block_end, block_end);
            mismatch_count++;
          end
        end
      end
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 299) == 0) begin
        calm_left = $urandom_range(50, 200);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (calm_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic test_saturating_sum();
    send_beat(make_beat(0, 200, 32'hFFFF_FFFE, 1'b0));
    send_beat(make_beat(1, 200, 32'd1, 1'b0));
    send_beat(make_beat(0, 300, '1, 1'b0));
    send_beat(make_beat(1, 300, '1, 1'b0));
  endtask

  task automatic test_key_extremes();
    send_beat(make_beat(0, '0, '0, 1'b0));
    send_beat(make_beat(1, KEY_ONES, '1, 1'b0));
    send_beat(make_beat(0, KEY_ONES, 32'd5, 1'b0));
  endtask

  task automatic test_overwrite_and_ignored();
    send_beat(make_beat(0, 50, 32'd7, 1'b0));
    send_beat(make_beat(0, 20, 32'd9, 1'b0));
    send_beat(make_beat(6, 1, 32'd1, 1'b0));
    send_beat(make_beat(1, 30, 32'd4, 1'b0));
  endtask

  task automatic test_exhaust_with_head();
    send_beat(make_beat(1, {$urandom, $urandom}, $urandom, 1'b1));
    send_beat(make_beat(1, 5, 32'd5, 1'b0));
    send_beat(make_beat(0, {$urandom, $urandom}, $urandom, 1'b1));
    send_beat(make_beat(3, 0, 32'd0, 1'b0));
  endtask

  // Shrinking the stream count leaves every remaining stream loaded, so the
  // next beat, even one for an inactive stream, releases a merged key.
  task automatic test_late_stream_count_change();
    wait_merges_done();
    write_stream_count(CFG_W'(3));
    send_beat(make_beat(0, 10, 32'd1, 1'b0));
    send_beat(make_beat(1, 10, 32'd1, 1'b0));
    wait_merges_done();
    write_stream_count(CFG_W'(2));
    send_beat(make_beat(7, 9, 32'd9, 1'b0));
  endtask

  task automatic test_stream_count_limits();
    wait_merges_done();
    write_stream_count(CFG_W'(0));
    send_beat(make_beat(0, 42, 32'd3, 1'b0));
    send_beat(make_beat(1, 43, 32'd3, 1'b0));
    send_beat(make_beat(0, 0, 32'd0, 1'b1));
    wait_merges_done();
    write_stream_count(CFG_W'(15));
    for (int i = 0; i < DEF_MAX_STREAMS; i++)
      send_beat(make_beat(i, 77, 32'h2000_0000, 1'b0));
  endtask

  task automatic run_merge_blocks(logic [CFG_W-1:0] setting, int unsigned beat_goal);
    int unsigned start;
    int unsigned n;
    int unsigned steps;
    int unsigned pick;
    int unsigned lane_left [DEF_MAX_STREAMS];
    logic [PORT_KEY_W-1:0] lane_next [DEF_MAX_STREAMS];
    logic [PORT_KEY_W-1:0] base;
    int unsigned roll;
    int unsigned want[$];
    wait_merges_done();
    write_stream_count(setting);
    start = accepted_beats;
    n = lanes_in_use();
    while (accepted_beats - start < beat_goal) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) base = KEY_ONES - 64'd30;
      else if (roll == 1) base = {$urandom, $urandom};
      else base = $urandom_range(0, 500);
      for (int i = 0; i < DEF_MAX_STREAMS; i++) begin
        lane_left[i] = $urandom_range(0, 6);
        lane_next[i] = base + $urandom_range(0, 3);
        if (lane_next[i] < base) lane_left[i] = 0;
      end
      block_closed = 1'b0;
      steps = 0;
      while (!block_closed && steps < 400) begin
        steps++;
        want.delete();
        for (int i = 0; i < n; i++)
          if (!lane_held[i] && !lane_done[i]) want.push_back(i);
        if (want.size() == 0 || $urandom_range(0, 9) == 0) begin
          send_beat(noise_beat());
        end else begin
          pick = want[$urandom_range(0, want.size() - 1)];
          if (lane_left[pick] == 0) begin
            send_beat(make_beat(pick, {$urandom, $urandom}, $urandom, 1'b1));
          end else begin
            send_beat(make_beat(pick, lane_next[pick], pick_count(), 1'b0));
            lane_left[pick]--;
            if (lane_next[pick] > KEY_ONES - 64'd3) lane_left[pick] = 0;
            else lane_next[pick] += $urandom_range(1, 3);
          end
        end
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings [12];
    int unsigned random_start;
    int unsigned idx;
    settings = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd2, 4'd0,
                 4'd5, 4'd9, 4'd7, 4'd4, 4'd6, 4'd2};
    lane_held = '0;
    lane_done = '0;
    for (int i = 0; i < DEF_MAX_STREAMS; i++) begin
      lane_key[i] = '0;
      lane_count[i] = '0;
    end
    stream_count_cfg = RESET_STREAM_COUNT;
    block_closed = 1'b0;
    mismatch_count = 0;
    accepted_beats = 0;
    merged_beats = 0;
    block_ends = 0;
    saturated_sums = 0;
    settings_used = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_saturating_sum();
    test_key_extremes();
    test_overwrite_and_ignored();
    test_exhaust_with_head();
    test_late_stream_count_change();
    test_stream_count_limits();

    random_start = accepted_beats;
    idx = 0;
    while (accepted_beats - random_start < RANDOM_BEATS) begin
      run_merge_blocks(settings[idx % 12], 150);
      idx++;
    end

    wait_merges_done();
    repeat (10) @(posedge clk);
    $display("Run covered %0d input beats, %0d merged keys and %0d block ends,",
             accepted_beats, merged_beats, block_ends);
    $display("with %0d saturated sums over %0d stream-count writes.",
             saturated_sums, settings_used);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
